>>> src/spi_tq_pkg.sv
// Shared types and constants for the SPI transmit transaction queue.
package spi_tq_pkg;

    localparam int BYTE_W           = 8;
    localparam int SEL_W            = 8;
    localparam int BYTE_DEPTH_DEF   = 64;
    localparam int QUEUE_DEPTH_DEF  = 8;
    localparam int SELECT_LINES_DEF = 8;

    localparam logic ACT_PUSH       = 1'b0;
    localparam logic ACT_SHIFT_DONE = 1'b1;

    typedef struct packed {
        logic             send_valid;
        logic [SEL_W-1:0] select_lines;
        logic             frame_end;
        logic             busy;
        logic             accepted;
    } result_t;

endpackage

>>> src/spi_tq_byte_ram.sv
// Transmit byte ring storage: one write port, one registered read port.
module spi_tq_byte_ram #(
    parameter int DEPTH = spi_tq_pkg::BYTE_DEPTH_DEF,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic                          clk,
    input  logic                          wr_en,
    input  logic [AW-1:0]                 wr_addr,
    input  logic [spi_tq_pkg::BYTE_W-1:0] wr_data,
    input  logic                          rd_en,
    input  logic [AW-1:0]                 rd_addr,
    output logic [spi_tq_pkg::BYTE_W-1:0] rd_data
);

    logic [spi_tq_pkg::BYTE_W-1:0] mem [DEPTH];
    logic [spi_tq_pkg::BYTE_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        // single-byte frame committed while idle: read hits the byte being written
        if (rd_en)
        begin
            rd_data_reg <= (wr_en && (wr_addr == rd_addr)) ? wr_data : mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> src/spi_tq_ctrl.sv
// Ring pointers, transaction slots and select line control.
module spi_tq_ctrl #(
    parameter int BYTE_DEPTH   = spi_tq_pkg::BYTE_DEPTH_DEF,
    parameter int QUEUE_DEPTH  = spi_tq_pkg::QUEUE_DEPTH_DEF,
    parameter int SELECT_LINES = spi_tq_pkg::SELECT_LINES_DEF,
    localparam int PW          = $clog2(BYTE_DEPTH),
    localparam int QW          = $clog2(QUEUE_DEPTH)
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         fire,
    input  logic                         action,
    input  logic [spi_tq_pkg::SEL_W-1:0] select_mask,
    input  logic                         last_byte,
    output logic                         wr_en,
    output logic [PW-1:0]                wr_addr,
    output logic                         rd_en,
    output logic [PW-1:0]                rd_addr,
    output spi_tq_pkg::result_t          res
);

    logic [QW-1:0]           head_reg, head_next;
    logic [QW-1:0]           tail_reg, tail_next;
    logic [PW-1:0]           write_pos_reg, write_pos_next;
    logic [PW-1:0]           committed_end_reg, committed_end_next;
    logic [PW-1:0]           read_pos_reg, read_pos_next;
    logic                    running_reg, running_next;
    logic [SELECT_LINES-1:0] select_reg, select_next;
    logic [SELECT_LINES-1:0] cur_sel_reg, cur_sel_next;
    logic [PW-1:0]           end_pos_reg [QUEUE_DEPTH];
    logic [SELECT_LINES-1:0] qsel_reg [QUEUE_DEPTH];

    logic                    q_wr;
    logic [SELECT_LINES-1:0] mask;
    logic [SELECT_LINES-1:0] released;
    logic [PW-1:0]           base;
    logic [PW-1:0]           wp_inc;
    logic [PW:0]             used;
    logic                    byte_full;
    logic                    queue_full;
    logic [QW-1:0]           nxt;
    logic                    at_end;
    logic [spi_tq_pkg::SEL_W-1:0] sel_out;

    function automatic logic [PW-1:0] byte_inc(input logic [PW-1:0] p);
        byte_inc = (p == PW'(BYTE_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    function automatic logic [QW-1:0] slot_inc(input logic [QW-1:0] s);
        slot_inc = (s == QW'(QUEUE_DEPTH - 1)) ? '0 : s + 1'b1;
    endfunction

    always_comb
    begin
        mask       = select_mask[SELECT_LINES-1:0];
        base       = running_reg ? read_pos_reg : committed_end_reg;
        used       = (write_pos_reg >= base)
                   ? {1'b0, write_pos_reg} - {1'b0, base}
                   : {1'b0, write_pos_reg} + (PW+1)'(BYTE_DEPTH) - {1'b0, base};
        byte_full  = used >= (PW+1)'(BYTE_DEPTH - 1);
        queue_full = last_byte && running_reg && (tail_reg == head_reg);
        wp_inc     = byte_inc(write_pos_reg);
        nxt        = slot_inc(head_reg);
        at_end     = read_pos_reg == end_pos_reg[head_reg];
        released   = select_reg | cur_sel_reg;

        head_next          = head_reg;
        tail_next          = tail_reg;
        write_pos_next     = write_pos_reg;
        committed_end_next = committed_end_reg;
        read_pos_next      = read_pos_reg;
        running_next       = running_reg;
        select_next        = select_reg;
        cur_sel_next       = cur_sel_reg;
        q_wr               = 1'b0;
        wr_en              = 1'b0;
        wr_addr            = write_pos_reg;
        rd_en              = 1'b0;
        rd_addr            = read_pos_reg;
        res                = '0;
        res.accepted       = 1'b1;

        if (fire)
        begin
            if (action == spi_tq_pkg::ACT_PUSH)
            begin
                if (byte_full || queue_full)
                begin
                    res.accepted = 1'b0;
                end
                else
                begin
                    wr_en          = 1'b1;
                    write_pos_next = wp_inc;
                    if (last_byte)
                    begin
                        q_wr               = 1'b1;
                        tail_next          = slot_inc(tail_reg);
                        committed_end_next = wp_inc;
                        if (!running_reg)
                        begin
                            // idle: start the new frame straight away
                            running_next   = 1'b1;
                            select_next    = select_reg & ~mask;
                            cur_sel_next   = mask;
                            head_next      = nxt;
                            rd_en          = 1'b1;
                            rd_addr        = committed_end_reg;
                            read_pos_next  = byte_inc(committed_end_reg);
                            res.send_valid = 1'b1;
                        end
                    end
                end
            end
            else if (running_reg)
            begin
                if (at_end)
                begin
                    res.frame_end = 1'b1;
                    if (nxt != tail_reg)
                    begin
                        head_next      = nxt;
                        select_next    = released & ~qsel_reg[nxt];
                        cur_sel_next   = qsel_reg[nxt];
                        rd_en          = 1'b1;
                        read_pos_next  = byte_inc(read_pos_reg);
                        res.send_valid = 1'b1;
                    end
                    else
                    begin
                        running_next = 1'b0;
                        select_next  = released;
                    end
                end
                else
                begin
                    rd_en          = 1'b1;
                    read_pos_next  = byte_inc(read_pos_reg);
                    res.send_valid = 1'b1;
                end
            end
        end

        sel_out                       = '1;
        sel_out[SELECT_LINES-1:0]     = select_next;
        res.select_lines              = sel_out;
        res.busy                      = running_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg          <= QW'(QUEUE_DEPTH - 1);
            tail_reg          <= '0;
            write_pos_reg     <= '0;
            committed_end_reg <= '0;
            read_pos_reg      <= '0;
            running_reg       <= 1'b0;
            select_reg        <= '1;
        end
        else
        begin
            head_reg          <= head_next;
            tail_reg          <= tail_next;
            write_pos_reg     <= write_pos_next;
            committed_end_reg <= committed_end_next;
            read_pos_reg      <= read_pos_next;
            running_reg       <= running_next;
            select_reg        <= select_next;
        end
    end

    // slot contents and current frame mask are payload, no reset
    always_ff @(posedge clk)
    begin
        cur_sel_reg <= cur_sel_next;
        if (q_wr)
        begin
            end_pos_reg[tail_reg] <= wp_inc;
            qsel_reg[tail_reg]    <= mask;
        end
    end

endmodule

>>> src/spi_transmit_transaction_queue_core.sv
// The result item of an accepted item is on the output register in the cycle after it is accepted.
// Throughput: one item per cycle; the next item is taken while a result waits if out_ready.
// Each item is handled in the cycle it is accepted; the byte ring read is registered.
// Reset: head = last slot; other pointers, running, out valid clear; select state all high.
// Byte ring and slot storage are not cleared: no clearing pass, ready right after reset.
module spi_transmit_transaction_queue_core #(
    parameter int BYTE_DEPTH   = spi_tq_pkg::BYTE_DEPTH_DEF,
    parameter int QUEUE_DEPTH  = spi_tq_pkg::QUEUE_DEPTH_DEF,
    parameter int SELECT_LINES = spi_tq_pkg::SELECT_LINES_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    // input item channel
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic                          action,
    input  logic [spi_tq_pkg::BYTE_W-1:0] data_byte,
    input  logic [spi_tq_pkg::SEL_W-1:0]  select_mask,
    input  logic                          last_byte,
    // result item channel
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic                          send_valid,
    output logic [spi_tq_pkg::BYTE_W-1:0] send_byte,
    output logic [spi_tq_pkg::SEL_W-1:0]  select_lines,
    output logic                          frame_end,
    output logic                          busy_res,
    output logic                          accepted
);

    localparam int PW = $clog2(BYTE_DEPTH);

    logic                          fire;
    logic                          wr_en;
    logic [PW-1:0]                 wr_addr;
    logic                          rd_en;
    logic [PW-1:0]                 rd_addr;
    logic [spi_tq_pkg::BYTE_W-1:0] rd_data;
    spi_tq_pkg::result_t           res;
    spi_tq_pkg::result_t           result_reg;
    logic                          out_valid_reg;

    // an item is taken whenever the result register is empty or being drained
    assign in_ready = !out_valid_reg || out_ready;
    assign fire     = in_valid && in_ready;

    spi_tq_ctrl #(
        .BYTE_DEPTH   (BYTE_DEPTH),
        .QUEUE_DEPTH  (QUEUE_DEPTH),
        .SELECT_LINES (SELECT_LINES)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .fire        (fire),
        .action      (action),
        .select_mask (select_mask),
        .last_byte   (last_byte),
        .wr_en       (wr_en),
        .wr_addr     (wr_addr),
        .rd_en       (rd_en),
        .rd_addr     (rd_addr),
        .res         (res)
    );

    // the read register only moves when an item sends a byte, so it holds under stall
    spi_tq_byte_ram #(
        .DEPTH (BYTE_DEPTH)
    ) u_byte_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (data_byte),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (fire)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            result_reg <= res;
        end
    end

    assign out_valid    = out_valid_reg;
    assign send_valid   = result_reg.send_valid;
    // no byte goes to the shifter: show zero
    assign send_byte    = result_reg.send_valid ? rd_data : '0;
    assign select_lines = result_reg.select_lines;
    assign frame_end    = result_reg.frame_end;
    assign busy_res     = result_reg.busy;
    assign accepted     = result_reg.accepted;

endmodule
